[rtl/cvi_pkg.sv]
// ----------------------------------------------------------------------------
// cvi_pkg
// Shared types and constants of the character video controller.
// ----------------------------------------------------------------------------
package cvi_pkg;

	localparam int PAGE_DEPTH  = 2048;
	localparam int GLYPH_DEPTH = 4096;
	localparam int CHAR_WIDTH  = 6;
	localparam int PAGE_AW     = $clog2(PAGE_DEPTH);
	localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);

	typedef enum logic [3:0] {
		REQ_PAGE_WR  = 4'd0,
		REQ_PAGE_RD  = 4'd1,
		REQ_GLYPH_WR = 4'd2,
		REQ_GLYPH_RD = 4'd3,
		REQ_CONTROL  = 4'd4,
		REQ_MODE     = 4'd5,
		REQ_PAGE_ADR = 4'd6,
		REQ_HOME_ADR = 4'd7,
		REQ_RENDER   = 4'd8
	} req_t;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [10:0] offset;
		logic [15:0] data;
		logic        color_bit_in;
		logic [5:0]  cell_column;
		logic [4:0]  cell_row;
		logic [3:0]  glyph_line;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       color_bit_out;
		logic [5:0] pixel_mask;
		logic [5:0] color_index;
		logic       blank;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_PAGE  = 2'd1,
		ST_GLYPH = 2'd2,
		ST_OUT   = 2'd3
	} state_t;

	function automatic logic [GLYPH_AW-1:0] glyph_index(logic [7:0] code, logic [3:0] line);
		logic [11:0] a;
		a = {1'b0, code, line[2:0]} + (line[3] ? 12'd2048 : 12'd0);
		return a[GLYPH_AW-1:0];
	endfunction

endpackage

[rtl/cvi_if.sv]
// ----------------------------------------------------------------------------
// cvi_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface cvi_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/cvi_mem.sv]
// ----------------------------------------------------------------------------
// cvi_mem
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cvi_mem #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[rtl/char_video_interface_core.sv]
// ----------------------------------------------------------------------------
// char_video_interface_core
// Character video controller: page RAM, glyph RAM and render lookup.
// ----------------------------------------------------------------------------
// One transaction in, one out. Register writes and page accesses reach the
// result register through the page state, then the output state. Glyph
// accesses and renders add the glyph state between: the page RAM read,
// then the dependent glyph RAM read. Glyph accesses with character memory
// off and blank renders skip the glyph state. The two single-port RAMs are
// the pacing resource. A new request is taken in the idle cycle after the
// previous one has entered the result register, so only one request is in
// flight. A request waits in its output state while the result register
// still holds an untaken result. No clearing pass after reset.
module char_video_interface_core (
	input logic clk,
	input logic arst_n,
	cvi_if.sink   in_ch,
	cvi_if.source out_ch
);
	cvi_pkg::state_t state_q, state_d;
	cvi_pkg::in_item_t req_q;
	logic [10:0] page_adr_q, home_adr_q;
	logic [4:0]  mode_q;
	logic [7:0]  ctl_q;
	logic        out_valid_q;
	cvi_pkg::out_item_t out_q, res;

	logic page_we, glyph_we;
	logic [cvi_pkg::PAGE_AW-1:0]  page_addr;
	logic [cvi_pkg::GLYPH_AW-1:0] glyph_addr;
	logic [7:0] page_rd, glyph_rd;
	logic       color_rd;
	logic       in_fire, out_free;

	// Fields of the captured request
	cvi_pkg::req_t req;
	logic [3:0]  lcount;
	logic        blank_c;
	logic [10:0] cpu_idx, rnd_idx;
	logic [10:0] row_mul;
	logic [1:0]  colmode;
	logic        r, g, b;
	logic [5:0]  cidx;

	assign req      = cvi_pkg::req_t'(req_q.req_type);
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == cvi_pkg::ST_IDLE);
	assign in_fire  = in_ch.valid && in_ch.ready;

	// Page index for CPU access: register path under character-memory mode
	assign cpu_idx = mode_q[0] ? (mode_q[3] ? page_adr_q : {1'b0, page_adr_q[9:0]})
		: req_q.offset;
	// Render address: home + row*cols + column, mod 2048
	assign row_mul = ctl_q[7]
		? (11'({req_q.cell_row, 5'b0}) + 11'({req_q.cell_row, 3'b0}))
		: (11'({req_q.cell_row, 4'b0}) + 11'({req_q.cell_row, 2'b0}));
	assign rnd_idx = home_adr_q + row_mul + 11'(req_q.cell_column);
	assign lcount  = (mode_q[2] && !mode_q[3]) ? 4'd0 : (!mode_q[1] ? 4'd9 : 4'd8);
	assign blank_c = ctl_q[4] || (lcount != 4'd0 && req_q.glyph_line >= lcount);

	always_comb begin
		page_we   = (state_q == cvi_pkg::ST_PAGE) && req == cvi_pkg::REQ_PAGE_WR;
		page_addr = cvi_pkg::PAGE_AW'(req == cvi_pkg::REQ_RENDER ? rnd_idx : cpu_idx);
		glyph_we  = (state_q == cvi_pkg::ST_GLYPH) && req == cvi_pkg::REQ_GLYPH_WR;
		glyph_addr = (req == cvi_pkg::REQ_RENDER)
			? cvi_pkg::glyph_index(page_rd, req_q.glyph_line)
			: cvi_pkg::glyph_index(page_rd, req_q.offset[3:0]);
	end

	cvi_mem #(.WIDTH(8), .DEPTH(cvi_pkg::PAGE_DEPTH)) u_page (
		.clk(clk), .we(page_we), .addr(page_addr), .wdata(req_q.data[7:0]),
		.rdata(page_rd)
	);
	cvi_mem #(.WIDTH(9), .DEPTH(cvi_pkg::GLYPH_DEPTH)) u_glyph (
		.clk(clk), .we(glyph_we), .addr(glyph_addr),
		.wdata({req_q.color_bit_in, req_q.data[7:0]}), .rdata({color_rd, glyph_rd})
	);

	// Color mapping of glyph bits 6 and 7 plus the stored color bit
	always_comb begin
		colmode = ctl_q[6:5];
		unique case (colmode)
			2'd0: begin r = glyph_rd[6]; g = color_rd; b = glyph_rd[7]; end
			2'd1: begin r = glyph_rd[6]; g = glyph_rd[7]; b = color_rd; end
			default: begin r = color_rd; g = glyph_rd[7]; b = glyph_rd[6]; end
		endcase
		cidx = {3'b000, r, b, g} + (ctl_q[3] ? {ctl_q[2:0], 3'b000} : 6'd0);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cvi_pkg::ST_IDLE:  if (in_fire) state_d = cvi_pkg::ST_PAGE;
			cvi_pkg::ST_PAGE: begin
				if ((req == cvi_pkg::REQ_GLYPH_WR || req == cvi_pkg::REQ_GLYPH_RD) && mode_q[0])
					state_d = cvi_pkg::ST_GLYPH;
				else if (req == cvi_pkg::REQ_RENDER && !blank_c)
					state_d = cvi_pkg::ST_GLYPH;
				else
					state_d = cvi_pkg::ST_OUT;
			end
			cvi_pkg::ST_GLYPH: state_d = cvi_pkg::ST_OUT;
			cvi_pkg::ST_OUT:   if (out_free) state_d = cvi_pkg::ST_IDLE;
			default:           state_d = cvi_pkg::ST_IDLE;
		endcase
	end

	// Result of the finishing request
	always_comb begin
		res = '0;
		unique case (req)
			cvi_pkg::REQ_PAGE_RD: res.read_data = page_rd;
			cvi_pkg::REQ_GLYPH_RD: if (mode_q[0]) begin
				res.read_data = glyph_rd;
				res.color_bit_out = color_rd;
			end
			cvi_pkg::REQ_RENDER: begin
				if (blank_c) res.blank = 1'b1;
				else begin
					res.pixel_mask  = glyph_rd[cvi_pkg::CHAR_WIDTH-1:0];
					res.color_index = cidx;
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cvi_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			page_adr_q  <= '0;
			home_adr_q  <= '0;
			mode_q      <= '0;
			ctl_q       <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (state_q == cvi_pkg::ST_OUT && out_free) out_valid_q <= 1'b1;
			// register writes commit in the page stage
			if (state_q == cvi_pkg::ST_PAGE) begin
				unique case (req)
					cvi_pkg::REQ_CONTROL:  ctl_q <= req_q.data[7:0];
					cvi_pkg::REQ_MODE:     mode_q <= {req_q.data[7], req_q.data[6],
						req_q.data[5], req_q.data[3], req_q.data[0]};
					cvi_pkg::REQ_PAGE_ADR: page_adr_q <= req_q.data[10:0];
					cvi_pkg::REQ_HOME_ADR: home_adr_q <= {req_q.data[10:2], 2'b00};
					default: ;
				endcase
			end
		end
	end

	// Payload registers; RAM addresses hold still until the output stage fires
	always_ff @(posedge clk) begin
		if (in_fire) req_q <= in_ch.payload;
		if (state_q == cvi_pkg::ST_OUT && out_free) out_q <= res;
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;
endmodule

[rtl/cvi_checker.sv]
// ----------------------------------------------------------------------------
// cvi_checker
// Port-level checks of the character video controller.
// ----------------------------------------------------------------------------
module cvi_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_blank,
	input logic [5:0] out_mask,
	input logic [5:0] out_cidx
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");
	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_blank |-> out_mask == 6'd0 && out_cidx == 6'd0)
		else $error("blank result carries pixels");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");
endmodule

bind char_video_interface_core cvi_checker u_cvi_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_blank(out_ch.payload.blank), .out_mask(out_ch.payload.pixel_mask),
	.out_cidx(out_ch.payload.color_index)
);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for char_video_interface_core: a directed table of
// requests followed by legal random traffic, every result compared with a
// behavioral copy of the controller kept alongside.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [3:0] REQ_SPARE_LO = 4'd9;
	localparam logic [3:0] REQ_SPARE_HI = 4'd15;
	localparam int N_RANDOM   = 1930;
	localparam int CALM_FROM  = 1750;   // no idling on either side past this item
	localparam int HOLD_LEN   = 300;    // long receiver hold-off, in cycles
	localparam int STALL_MAX  = 4000;   // cycles without any transaction

	logic clk;
	logic arst_n;

	cvi_if #(.payload_t(cvi_pkg::in_item_t))  req_ch ();
	cvi_if #(.payload_t(cvi_pkg::out_item_t)) rsp_ch ();

	char_video_interface_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch.sink),
		.out_ch (rsp_ch.source)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// ---------------------------------------------------------------- shadow
	logic [7:0]  page_mem   [cvi_pkg::PAGE_DEPTH];
	logic [7:0]  glyph_mem  [cvi_pkg::GLYPH_DEPTH];
	logic        glyph_tint [cvi_pkg::GLYPH_DEPTH];
	bit          page_seen  [cvi_pkg::PAGE_DEPTH];
	bit          glyph_seen [cvi_pkg::GLYPH_DEPTH];
	logic [10:0] vid_page_adr;
	logic [10:0] vid_home_adr;
	logic [4:0]  vid_mode;   // cmem, line9, line16, dblpage, fresvert from bit 0
	logic [7:0]  vid_ctrl;

	typedef struct {
		cvi_pkg::in_item_t  item;
		bit                 typed;
		cvi_pkg::out_item_t want;
	} pending_t;

	pending_t  offered_q[$];            // predicted, not yet taken by the block
	cvi_pkg::out_item_t result_q[$];    // taken, result still due
	pending_t  dir_rows[$];

	int errors;
	int sent;
	bit calm;
	bit hold_done;

	function automatic logic [10:0] cpu_page(logic [10:0] off);
		if (vid_mode[0])
			return vid_mode[3] ? vid_page_adr : {1'b0, vid_page_adr[9:0]};
		return off;
	endfunction

	function automatic logic [11:0] glyph_slot(logic [7:0] code, logic [3:0] line);
		return {line[3], code, line[2:0]};
	endfunction

	function automatic int rows_lines();
		if (vid_mode[2] && !vid_mode[3])
			return 16;
		if (!vid_mode[1])
			return 9;
		return 8;
	endfunction

	function automatic logic [10:0] render_page(cvi_pkg::in_item_t it);
		int cols;
		cols = vid_ctrl[7] ? 40 : 20;
		return 11'(vid_home_adr + it.cell_row * cols + it.cell_column);
	endfunction

	function automatic bit render_blank(cvi_pkg::in_item_t it);
		return vid_ctrl[4] || (it.glyph_line >= rows_lines());
	endfunction

	// true when the request reads no RAM entry that was never written
	function automatic bit is_legal(cvi_pkg::in_item_t it);
		logic [10:0] pa;
		case (it.req_type)
			cvi_pkg::REQ_PAGE_RD:  return page_seen[cpu_page(it.offset)];
			cvi_pkg::REQ_GLYPH_WR: return !vid_mode[0] || page_seen[cpu_page(it.offset)];
			cvi_pkg::REQ_GLYPH_RD: begin
				if (!vid_mode[0])
					return 1;
				pa = cpu_page(it.offset);
				if (!page_seen[pa])
					return 0;
				return glyph_seen[glyph_slot(page_mem[pa], it.offset[3:0])];
			end
			cvi_pkg::REQ_RENDER: begin
				if (render_blank(it))
					return 1;
				pa = render_page(it);
				if (!page_seen[pa])
					return 0;
				return glyph_seen[glyph_slot(page_mem[pa], it.glyph_line)];
			end
			default: return 1;
		endcase
	endfunction

	function automatic logic [5:0] tint_index(logic c0, logic c1, logic pc);
		logic r, g, b;
		logic [5:0] v;
		case (vid_ctrl[6:5])
			2'd0:    begin r = c0; g = pc; b = c1; end
			2'd1:    begin r = c0; g = c1; b = pc; end
			default: begin r = pc; g = c1; b = c0; end   // mode three acts as two
		endcase
		v = {3'b000, r, b, g};
		if (vid_ctrl[3])
			v = v + {vid_ctrl[2:0], 3'b000};
		return v;
	endfunction

	// expected result of one request; advances the shadow state
	function automatic cvi_pkg::out_item_t video_step(cvi_pkg::in_item_t it);
		cvi_pkg::out_item_t o;
		logic [10:0] pa;
		logic [11:0] gi;
		logic [7:0]  g;
		o = '0;
		case (it.req_type)
			cvi_pkg::REQ_PAGE_WR: begin
				pa = cpu_page(it.offset);
				page_mem[pa] = it.data[7:0];
				page_seen[pa] = 1;
			end
			cvi_pkg::REQ_PAGE_RD: o.read_data = page_mem[cpu_page(it.offset)];
			cvi_pkg::REQ_GLYPH_WR: if (vid_mode[0]) begin
				gi = glyph_slot(page_mem[cpu_page(it.offset)], it.offset[3:0]);
				glyph_mem[gi] = it.data[7:0];
				glyph_tint[gi] = it.color_bit_in;
				glyph_seen[gi] = 1;
			end
			cvi_pkg::REQ_GLYPH_RD: if (vid_mode[0]) begin
				gi = glyph_slot(page_mem[cpu_page(it.offset)], it.offset[3:0]);
				o.read_data = glyph_mem[gi];
				o.color_bit_out = glyph_tint[gi];
			end
			cvi_pkg::REQ_CONTROL:  vid_ctrl = it.data[7:0];
			cvi_pkg::REQ_MODE:     vid_mode = {it.data[7], it.data[6], it.data[5],
				it.data[3], it.data[0]};
			cvi_pkg::REQ_PAGE_ADR: vid_page_adr = it.data[10:0];
			cvi_pkg::REQ_HOME_ADR: vid_home_adr = {it.data[10:2], 2'b00};
			cvi_pkg::REQ_RENDER: begin
				if (render_blank(it)) begin
					o.blank = 1;
				end else begin
					gi = glyph_slot(page_mem[render_page(it)], it.glyph_line);
					g = glyph_mem[gi];
					o.pixel_mask = g[5:0];
					o.color_index = tint_index(g[6], g[7], glyph_tint[gi]);
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// ------------------------------------------------------------- stimulus
	function automatic cvi_pkg::in_item_t random_request();
		cvi_pkg::in_item_t it;
		int pick;
		bit near;
		it = '0;
		it.offset = 11'($urandom);
		it.data = 16'($urandom);
		it.color_bit_in = 1'($urandom);
		it.glyph_line = 4'($urandom);
		near = $urandom_range(0, 99) < 85;
		it.cell_column = 6'($urandom_range(0, near ? 3 : 39));
		it.cell_row = 5'($urandom_range(0, near ? 2 : 24));
		pick = $urandom_range(0, 99);
		if (pick < 34) begin
			it.req_type = cvi_pkg::REQ_RENDER;
		end else if (pick < 54) begin
			it.req_type = cvi_pkg::REQ_PAGE_WR;
			if (near) begin
				it.offset = 11'($urandom_range(0, 63));
				it.data[7:0] = 8'($urandom_range(0, 7));
			end
		end else if (pick < 63) begin
			it.req_type = cvi_pkg::REQ_PAGE_RD;
		end else if (pick < 78) begin
			it.req_type = cvi_pkg::REQ_GLYPH_WR;
		end else if (pick < 86) begin
			it.req_type = cvi_pkg::REQ_GLYPH_RD;
		end else if (pick < 90) begin
			it.req_type = cvi_pkg::REQ_CONTROL;
			if ($urandom_range(0, 99) < 70)
				it.data[4] = 0;
		end else if (pick < 94) begin
			it.req_type = cvi_pkg::REQ_MODE;
			if ($urandom_range(0, 99) < 75)
				it.data[0] = 1;
		end else if (pick < 97) begin
			it.req_type = cvi_pkg::REQ_PAGE_ADR;
			if (near)
				it.data = 16'($urandom_range(0, 63));
		end else if (pick < 99) begin
			it.req_type = cvi_pkg::REQ_HOME_ADR;
			if (near)
				it.data = 16'($urandom_range(0, 15) * 4);
		end else begin
			it.req_type = 4'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		end
		return it;
	endfunction

	task automatic add_row(logic [3:0] rq, logic [10:0] off, logic [15:0] d, logic cb,
			logic [5:0] col, logic [4:0] row, logic [3:0] ln,
			bit typed, logic [7:0] rd, logic cbo, logic blk);
		pending_t p;
		p.item = '{rq, off, d, cb, col, row, ln};
		p.typed = typed;
		p.want = '{rd, cbo, 6'd0, 6'd0, blk};
		dir_rows.push_back(p);
	endtask

	// one item offered at the falling edge, held until taken
	task automatic offer(pending_t p);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		offered_q.push_back(p);
		req_ch.valid <= 1'b1;
		req_ch.payload <= p.item;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		if (sent > CALM_FROM)
			calm = 1;
	endtask

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on %s: got %0h, want %0h (time %0t)", field, got, want, $realtime);
		errors++;
	endtask

	initial begin
		pending_t           p;
		cvi_pkg::in_item_t  it;
		int                 tries;
		errors = 0;
		sent = 0;
		calm = 0;
		vid_page_adr = '0;
		vid_home_adr = '0;
		vid_mode = '0;
		vid_ctrl = '0;
		foreach (page_seen[i]) page_seen[i] = 0;
		foreach (glyph_seen[i]) glyph_seen[i] = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;

		// register write after reset, and render blank past line nine
		add_row(cvi_pkg::REQ_CONTROL,  11'h000, 16'h0000, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_RENDER,   11'h000, 16'h0000, 0, 0, 0, 4'hf, 1, 8'h00, 0, 1);
		// page RAM at both ends of the offset range
		add_row(cvi_pkg::REQ_PAGE_WR,  11'h000, 16'hffff, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_PAGE_RD,  11'h000, 16'h0000, 0, 0, 0, 0, 1, 8'hff, 0, 0);
		add_row(cvi_pkg::REQ_PAGE_WR,  11'h7ff, 16'h0000, 1, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_PAGE_RD,  11'h7ff, 16'hffff, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		// glyph access with character memory off: read zero, write dropped
		add_row(cvi_pkg::REQ_GLYPH_RD, 11'h7ff, 16'h0000, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_GLYPH_WR, 11'h7ff, 16'hffff, 1, 0, 0, 0, 1, 8'h00, 0, 0);
		// character memory plus double page: full 11-bit page address
		add_row(cvi_pkg::REQ_MODE,     11'h000, 16'h0041, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_PAGE_ADR, 11'h000, 16'hffff, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_GLYPH_WR, 11'h002, 16'h00c5, 1, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_GLYPH_RD, 11'h7f2, 16'h0000, 0, 0, 0, 0, 1, 8'hc5, 1, 0);
		add_row(cvi_pkg::REQ_HOME_ADR, 11'h000, 16'hffff, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		// home 0x7fc + 3 lands on the last page entry
		add_row(cvi_pkg::REQ_RENDER,   11'h000, 16'h0000, 0, 6'd3, 0, 4'd2, 0, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_CONTROL,  11'h000, 16'h00ef, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_RENDER,   11'h7ff, 16'hffff, 1, 6'd3, 0, 4'd2, 0, 8'h00, 0, 0);
		// display off
		add_row(cvi_pkg::REQ_CONTROL,  11'h000, 16'h00ff, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_RENDER,   11'h000, 16'h0000, 0, 6'd39, 5'd24, 4'd2,
			1, 8'h00, 0, 1);
		// unused code: nothing changes, all zero back
		add_row(REQ_SPARE_HI, 11'h7ff, 16'hffff, 1, 6'd63, 5'd31, 4'hf, 1, 8'h00, 0, 0);
		// every mode bit: eight lines per row
		add_row(cvi_pkg::REQ_MODE,     11'h000, 16'hffff, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_CONTROL,  11'h000, 16'h0000, 0, 0, 0, 0, 1, 8'h00, 0, 0);
		add_row(cvi_pkg::REQ_RENDER,   11'h000, 16'h0000, 0, 6'd3, 0, 4'd8, 1, 8'h00, 0, 1);
		add_row(cvi_pkg::REQ_RENDER,   11'h000, 16'h0000, 0, 6'd3, 0, 4'd2, 0, 8'h00, 0, 0);

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			p = dir_rows[i];
			if (p.typed)
				void'(video_step(p.item));
			else
				p.want = video_step(p.item);
			offer(p);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			tries = 0;
			it = random_request();
			while (!is_legal(it) && tries < 40) begin
				it = random_request();
				tries++;
			end
			if (!is_legal(it)) begin
				it.req_type = cvi_pkg::REQ_PAGE_WR;
				it.data[7:0] = 8'($urandom_range(0, 7));
			end
			p.item = it;
			p.typed = 0;
			p.want = video_step(it);
			offer(p);
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;

		wait (offered_q.size() == 0 && result_q.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[char_video_interface_core] OK");
		else
			$display("[char_video_interface_core] ERROR");
		$finish;
	end

	// input side: a taken transaction moves its prediction to the result queue
	always @(posedge clk) begin
		pending_t p;
		if (req_ch.valid && req_ch.ready) begin
			p = offered_q.pop_front();
			result_q.push_back(p.want);
		end
	end

	// receiver: random stalls, one long hold-off while the sender keeps offering
	initial begin
		int gap;
		hold_done = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && sent > 400) begin
				hold_done = 1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_LEN - 1) @(negedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 5);
				rsp_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// output side: field-by-field check against the oldest prediction
	always @(posedge clk) begin
		cvi_pkg::out_item_t got;
		cvi_pkg::out_item_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			if (result_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = result_q.pop_front();
				if (got.read_data !== want.read_data)
					report_mismatch("read_data", got.read_data, want.read_data);
				if (got.color_bit_out !== want.color_bit_out)
					report_mismatch("color_bit_out", got.color_bit_out, want.color_bit_out);
				if (got.pixel_mask !== want.pixel_mask)
					report_mismatch("pixel_mask", got.pixel_mask, want.pixel_mask);
				if (got.color_index !== want.color_index)
					report_mismatch("color_index", got.color_index, want.color_index);
				if (got.blank !== want.blank)
					report_mismatch("blank", got.blank, want.blank);
			end
		end
	end

	// watchdog: cycles without a transaction on either channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_MAX) begin
				$display("timeout: no transaction for %0d cycles", STALL_MAX);
				$display("[char_video_interface_core] ERROR");
				$finish;
			end
		end
	end

endmodule
